// ===== rtl/slru_pkg.sv =====
// ----------------------------------------------------------------------------
// slru_pkg
// Shared types, codes and constants of the segmented-LRU cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package slru_pkg;

  // Default sizes handed to the top level.
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 32;

  // Fixed field widths of the ports.
  localparam int OP_W     = 4;
  localparam int IN_KEY_W = 32;
  localparam int OUT_KEY_W = 32;
  localparam int SLOT_W   = 4;
  localparam int LIM_W    = 5;
  localparam logic [LIM_W-1:0] LIM_RESET = 5'd8;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_PROBATION = 1'b0,
    CFG_PROTECTED = 1'b1
  } cfg_idx_t;

  // Operation codes of an input word.
  typedef enum logic [OP_W-1:0] {
    OP_READ      = 4'd0,
    OP_FIND      = 4'd1,
    OP_WRITE     = 4'd2,
    OP_WRITE_THR = 4'd3,
    OP_INVAL     = 4'd4,
    OP_COMPLETE  = 4'd5,
    OP_DIRTY     = 4'd6,
    OP_CLEAN     = 4'd7,
    OP_BUSY      = 4'd8,
    OP_READONLY  = 4'd9,
    OP_READWRITE = 4'd10,
    OP_FLUSH     = 4'd11
  } op_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FETCH  = 2'd1,
    KIND_WB     = 2'd2
  } kind_t;

  // Final status codes.
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_NOT_CACHED = 3'd1,
    STAT_BUSY       = 3'd2,
    STAT_DIRTY      = 3'd3,
    STAT_READONLY   = 3'd4,
    STAT_NO_ROOM    = 3'd5
  } status_t;

  // Per-entry marks kept in the entry memory (valid lives in flops).
  typedef struct packed {
    logic ro;
    logic prot;
    logic dirty;
    logic busy;
  } marks_t;

  // Field write enables of the entry memory.
  typedef struct packed {
    logic key;
    logic marks;
    logic nxt;
    logic prv;
  } wen_t;

  // One result word.
  typedef struct packed {
    kind_t                 kind;
    logic [OUT_KEY_W-1:0]  key;
    logic [SLOT_W-1:0]     slot;
    status_t               status;
    logic                  last;
  } res_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISP,
    ST_EMIT,
    ST_RD_WAIT,
    ST_UL1,
    ST_UL2,
    ST_AP1,
    ST_AP2,
    ST_P_CHK,
    ST_P_DEM,
    ST_P_APP_O,
    ST_APP_S,
    ST_FIN_OK,
    ST_AC_START,
    ST_AC_CHK,
    ST_AC_EV,
    ST_AC_RM,
    ST_WR_RM,
    ST_NW_WR,
    ST_NW_POST,
    ST_FL_START,
    ST_FL_END
  } st_t;

  // Builds one result word.
  function automatic res_t mk_res(kind_t k, logic [OUT_KEY_W-1:0] key,
                                  logic [SLOT_W-1:0] slot, status_t s, logic last);
    res_t r;
    r.kind   = k;
    r.key    = key;
    r.slot   = slot;
    r.status = s;
    r.last   = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/slru_mem.sv =====
// ----------------------------------------------------------------------------
// slru_mem
// Entry memory: key, marks and segment links per slot, with field write
// enables and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slru_mem
  import slru_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int SW = $clog2(ENTRIES),
  localparam int PW = $clog2(ENTRIES + 1)
) (
  input  wire logic                clk,
  input  wire logic [SW-1:0]       waddr,
  input  wire wen_t                we,
  input  wire logic [KEY_BITS-1:0] wkey,
  input  wire marks_t              wmarks,
  input  wire logic [PW-1:0]       wnext,
  input  wire logic [PW-1:0]       wprev,
  input  wire logic [SW-1:0]       raddr,
  output logic [KEY_BITS-1:0]      rkey,
  output marks_t                   rmarks,
  output logic [PW-1:0]            rnext,
  output logic [PW-1:0]            rprev
);

  logic [KEY_BITS-1:0] key_mem   [ENTRIES];
  marks_t              marks_mem [ENTRIES];
  logic [PW-1:0]       next_mem  [ENTRIES];
  logic [PW-1:0]       prev_mem  [ENTRIES];

  // Write port, one enable per field.
  always_ff @(posedge clk) begin
    if (we.key)   key_mem[waddr]   <= wkey;
    if (we.marks) marks_mem[waddr] <= wmarks;
    if (we.nxt)   next_mem[waddr]  <= wnext;
    if (we.prv)   prev_mem[waddr]  <= wprev;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rkey   <= key_mem[raddr];
    rmarks <= marks_mem[raddr];
    rnext  <= next_mem[raddr];
    rprev  <= prev_mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/slru_ctrl.sv =====
// ----------------------------------------------------------------------------
// slru_ctrl
// Sequencer: key scan, segment list relinking, eviction walk and flush passes
// over the entry memory, one memory access per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slru_ctrl
  import slru_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int SW = $clog2(ENTRIES),
  localparam int PW = $clog2(ENTRIES + 1),
  localparam int CW = (PW + 1 > LIM_W) ? PW + 1 : LIM_W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [IN_KEY_W-1:0] in_key,
  input  wire logic [LIM_W-1:0]    plim,
  input  wire logic [LIM_W-1:0]    qlim,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output res_t                     res,
  output logic [SW-1:0]            m_waddr,
  output wen_t                     m_we,
  output logic [KEY_BITS-1:0]      m_wkey,
  output marks_t                   m_wmarks,
  output logic [PW-1:0]            m_wnext,
  output logic [PW-1:0]            m_wprev,
  output logic [SW-1:0]            m_raddr,
  input  wire logic [KEY_BITS-1:0] m_rkey,
  input  wire marks_t              m_rmarks,
  input  wire logic [PW-1:0]       m_rnext,
  input  wire logic [PW-1:0]       m_rprev
);

  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  // Control state.
  st_t               st_r, st_nxt, ret_r, ret_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [PW-1:0]     head_r [2];
  logic [PW-1:0]     head_nxt [2];
  logic [PW-1:0]     tail_r [2];
  logic [PW-1:0]     tail_nxt [2];
  logic [PW-1:0]     cseg_r [2];
  logic [PW-1:0]     cseg_nxt [2];

  // Operation and scan results.
  op_t               op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [SW-1:0]     pidx_r, pidx_nxt;
  logic              found_r, found_nxt;
  logic [SW-1:0]     s_r, s_nxt;
  logic [KEY_BITS-1:0] swkey_r, swkey_nxt;
  marks_t            swm_r, swm_nxt;
  logic [PW-1:0]     swnext_r, swnext_nxt;
  logic [PW-1:0]     swprev_r, swprev_nxt;
  logic [PW-1:0]     free_r, free_nxt;
  logic              bf_r, bf_nxt;
  logic [SW-1:0]     bslot_r, bslot_nxt;
  logic [KEY_BITS-1:0] bkey_r, bkey_nxt;
  marks_t            bm_r, bm_nxt;

  // Read capture, link procedure operands, eviction walk.
  logic [KEY_BITS-1:0] rdkey_r, rdkey_nxt;
  marks_t            rdm_r, rdm_nxt;
  logic [PW-1:0]     rdnext_r, rdnext_nxt;
  logic [PW-1:0]     rdprev_r, rdprev_nxt;
  logic [SW-1:0]     uslot_r, uslot_nxt;
  logic [PW-1:0]     uprev_r, uprev_nxt;
  logic [PW-1:0]     unext_r, unext_nxt;
  logic              useg_r, useg_nxt;
  logic [SW-1:0]     aslot_r, aslot_nxt;
  logic              aseg_r, aseg_nxt;
  logic              tgt_r, tgt_nxt;
  marks_t            nm_r, nm_nxt;
  logic [PW-1:0]     walk_r, walk_nxt;
  res_t              res_r, res_nxt;

  logic              short_room;
  logic [SW-1:0]     walk_s;
  logic [PW-1:0]     ap_tail;

  assign in_ready  = (st_r == ST_IDLE);
  assign res_valid = (st_r == ST_EMIT);
  assign res       = res_r;
  assign walk_s    = walk_r[SW-1:0];
  assign ap_tail   = tail_r[aseg_r];

  // Room check: probationary count plus one over its limit, or no free slot.
  assign short_room = ((CW'(cseg_r[0]) + CW'(1)) > CW'(plim)) || (free_r == NIL);

  // Next state, memory accesses and result words.
  always_comb begin
    st_nxt     = st_r;
    ret_nxt    = ret_r;
    valid_nxt  = valid_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cseg_nxt   = cseg_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    found_nxt  = found_r;
    s_nxt      = s_r;
    swkey_nxt  = swkey_r;
    swm_nxt    = swm_r;
    swnext_nxt = swnext_r;
    swprev_nxt = swprev_r;
    free_nxt   = free_r;
    bf_nxt     = bf_r;
    bslot_nxt  = bslot_r;
    bkey_nxt   = bkey_r;
    bm_nxt     = bm_r;
    rdkey_nxt  = rdkey_r;
    rdm_nxt    = rdm_r;
    rdnext_nxt = rdnext_r;
    rdprev_nxt = rdprev_r;
    uslot_nxt  = uslot_r;
    uprev_nxt  = uprev_r;
    unext_nxt  = unext_r;
    useg_nxt   = useg_r;
    aslot_nxt  = aslot_r;
    aseg_nxt   = aseg_r;
    tgt_nxt    = tgt_r;
    nm_nxt     = nm_r;
    walk_nxt   = walk_r;
    res_nxt    = res_r;
    m_waddr    = s_r;
    m_we       = '0;
    m_wkey     = key_r;
    m_wmarks   = swm_r;
    m_wnext    = NIL;
    m_wprev    = NIL;
    m_raddr    = cnt_r[SW-1:0];

    case (st_r)
      // Take a new word and start the key scan.
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_op);
          key_nxt   = KEY_BITS'(in_key);
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          free_nxt  = NIL;
          bf_nxt    = 1'b0;
          st_nxt    = ST_SCAN;
        end
      end

      // Restart the scan for the next flush pass.
      ST_FL_START: begin
        cnt_nxt  = '0;
        pend_nxt = 1'b0;
        bf_nxt   = 1'b0;
        st_nxt   = ST_SCAN;
      end

      // Read one slot a cycle; check the slot read the cycle before.
      ST_SCAN: begin
        if (pend_r) begin
          if (valid_r[pidx_r]) begin
            if (m_rkey == key_r) begin
              found_nxt  = 1'b1;
              s_nxt      = pidx_r;
              swkey_nxt  = m_rkey;
              swm_nxt    = m_rmarks;
              swnext_nxt = m_rnext;
              swprev_nxt = m_rprev;
            end
            if (m_rmarks.dirty && (!bf_r || (m_rkey < bkey_r))) begin
              bf_nxt    = 1'b1;
              bslot_nxt = pidx_r;
              bkey_nxt  = m_rkey;
              bm_nxt    = m_rmarks;
            end
          end else if (free_r == NIL) begin
            free_nxt = PW'(pidx_r);
          end
        end
        if (cnt_r != NIL) begin
          m_raddr  = cnt_r[SW-1:0];
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[SW-1:0];
          cnt_nxt  = cnt_r + PW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            st_nxt = (op_r == OP_FLUSH) ? ST_FL_END : ST_DISP;
          end
        end
      end

      // Decide on the operation once the lookup is known.
      ST_DISP: begin
        uslot_nxt = s_r;
        uprev_nxt = swprev_r;
        unext_nxt = swnext_r;
        useg_nxt  = swm_r.prot;
        case (op_r)
          OP_READ, OP_FIND, OP_BUSY: begin
            if (found_r) begin
              // Hit: mark busy and protected, then requeue or promote.
              m_we.marks = 1'b1;
              m_wmarks   = swm_r;
              m_wmarks.busy = 1'b1;
              m_wmarks.prot = 1'b1;
              tgt_nxt    = 1'b1;
              st_nxt     = ST_UL1;
              ret_nxt    = swm_r.prot ? ST_APP_S : ST_P_CHK;
            end else if (op_r == OP_READ) begin
              nm_nxt      = '0;
              nm_nxt.busy = 1'b1;
              tgt_nxt     = 1'b0;
              res_nxt = mk_res(KIND_FETCH, OUT_KEY_W'(key_r), '0, STAT_OK, 1'b0);
              st_nxt  = ST_EMIT;
              ret_nxt = ST_AC_START;
            end else begin
              res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_NOT_CACHED, 1'b1);
              st_nxt  = ST_EMIT;
              ret_nxt = ST_IDLE;
            end
          end
          OP_WRITE, OP_WRITE_THR: begin
            if (found_r && swm_r.busy) begin
              res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_BUSY, 1'b1);
              st_nxt  = ST_EMIT;
              ret_nxt = ST_IDLE;
            end else if (found_r && swm_r.ro) begin
              res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_READONLY, 1'b1);
              st_nxt  = ST_EMIT;
              ret_nxt = ST_IDLE;
            end else begin
              nm_nxt       = '0;
              nm_nxt.busy  = 1'b1;
              nm_nxt.dirty = (op_r == OP_WRITE);
              nm_nxt.prot  = found_r && swm_r.prot;
              tgt_nxt      = found_r && swm_r.prot;
              if (!found_r) begin
                st_nxt = ST_AC_START;
              end else if (swm_r.dirty) begin
                res_nxt = mk_res(KIND_WB, OUT_KEY_W'(swkey_r), SLOT_W'(s_r), STAT_OK, 1'b0);
                st_nxt  = ST_EMIT;
                ret_nxt = ST_WR_RM;
              end else begin
                st_nxt = ST_WR_RM;
              end
            end
          end
          OP_INVAL: begin
            if (!found_r) begin
              res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_NOT_CACHED, 1'b1);
              st_nxt  = ST_EMIT;
              ret_nxt = ST_IDLE;
            end else begin
              m_we.marks    = 1'b1;
              m_wmarks      = swm_r;
              m_wmarks.busy = 1'b0;
              if (swm_r.dirty) begin
                res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_DIRTY, 1'b1);
                st_nxt  = ST_EMIT;
                ret_nxt = ST_IDLE;
              end else begin
                valid_nxt[s_r] = 1'b0;
                st_nxt  = ST_UL1;
                ret_nxt = ST_FIN_OK;
              end
            end
          end
          OP_COMPLETE, OP_DIRTY, OP_CLEAN, OP_READONLY, OP_READWRITE: begin
            if (!found_r) begin
              res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_NOT_CACHED, 1'b1);
              st_nxt  = ST_EMIT;
              ret_nxt = ST_IDLE;
            end else if (op_r == OP_DIRTY && swm_r.ro) begin
              res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_READONLY, 1'b1);
              st_nxt  = ST_EMIT;
              ret_nxt = ST_IDLE;
            end else begin
              m_we.marks = 1'b1;
              m_wmarks   = swm_r;
              tgt_nxt    = swm_r.prot;
              st_nxt     = ST_UL1;
              ret_nxt    = ST_APP_S;
              case (op_r)
                OP_COMPLETE: begin
                  m_wmarks.busy = 1'b0;
                  st_nxt        = ST_FIN_OK;
                end
                OP_DIRTY:     m_wmarks.dirty = 1'b1;
                OP_CLEAN:     m_wmarks.dirty = 1'b0;
                OP_READONLY:  m_wmarks.ro    = 1'b1;
                default:      m_wmarks.ro    = 1'b0;
              endcase
            end
          end
          default: begin
            res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_OK, 1'b1);
            st_nxt  = ST_EMIT;
            ret_nxt = ST_IDLE;
          end
        endcase
      end

      // Hold a result word until the output register takes it.
      ST_EMIT: begin
        if (res_ready) st_nxt = ret_r;
      end

      // Capture the word read the cycle before.
      ST_RD_WAIT: begin
        rdkey_nxt  = m_rkey;
        rdm_nxt    = m_rmarks;
        rdnext_nxt = m_rnext;
        rdprev_nxt = m_rprev;
        st_nxt     = ret_r;
      end

      // Unlink, first half: forward link of the predecessor or the head.
      ST_UL1: begin
        if (uprev_r != NIL) begin
          m_waddr  = uprev_r[SW-1:0];
          m_we.nxt = 1'b1;
          m_wnext  = unext_r;
        end else begin
          head_nxt[useg_r] = unext_r;
        end
        st_nxt = ST_UL2;
      end

      // Unlink, second half: back link of the successor or the tail.
      ST_UL2: begin
        if (unext_r != NIL) begin
          m_waddr  = unext_r[SW-1:0];
          m_we.prv = 1'b1;
          m_wprev  = uprev_r;
        end else begin
          tail_nxt[useg_r] = uprev_r;
        end
        if (cseg_r[useg_r] != '0) cseg_nxt[useg_r] = cseg_r[useg_r] - PW'(1);
        st_nxt = ret_r;
      end

      // Append, first half: links of the new tail.
      ST_AP1: begin
        m_waddr  = aslot_r;
        m_we.nxt = 1'b1;
        m_we.prv = 1'b1;
        m_wnext  = NIL;
        m_wprev  = ap_tail;
        st_nxt   = ST_AP2;
      end

      // Append, second half: old tail or head points at the new slot.
      ST_AP2: begin
        if (ap_tail != NIL) begin
          m_waddr  = ap_tail[SW-1:0];
          m_we.nxt = 1'b1;
          m_wnext  = PW'(aslot_r);
        end else begin
          head_nxt[aseg_r] = PW'(aslot_r);
        end
        tail_nxt[aseg_r] = PW'(aslot_r);
        cseg_nxt[aseg_r] = cseg_r[aseg_r] + PW'(1);
        st_nxt = ret_r;
      end

      // Promotion: demote the oldest protected entry when that segment is full.
      ST_P_CHK: begin
        if ((CW'(cseg_r[1]) >= CW'(qlim)) && (head_r[1] != NIL)) begin
          m_raddr   = head_r[1][SW-1:0];
          uslot_nxt = head_r[1][SW-1:0];
          st_nxt    = ST_RD_WAIT;
          ret_nxt   = ST_P_DEM;
        end else begin
          st_nxt = ST_APP_S;
        end
      end

      ST_P_DEM: begin
        m_waddr       = uslot_r;
        m_we.marks    = 1'b1;
        m_wmarks      = rdm_r;
        m_wmarks.prot = 1'b0;
        uprev_nxt     = rdprev_r;
        unext_nxt     = rdnext_r;
        useg_nxt      = 1'b1;
        st_nxt        = ST_UL1;
        ret_nxt       = ST_P_APP_O;
      end

      ST_P_APP_O: begin
        aslot_nxt = uslot_r;
        aseg_nxt  = 1'b0;
        st_nxt    = ST_AP1;
        ret_nxt   = ST_APP_S;
      end

      // Operated entry goes to the tail of its target segment.
      ST_APP_S: begin
        aslot_nxt = s_r;
        aseg_nxt  = tgt_r;
        st_nxt    = ST_AP1;
        ret_nxt   = ST_FIN_OK;
      end

      ST_FIN_OK: begin
        res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), SLOT_W'(s_r), STAT_OK, 1'b1);
        st_nxt  = ST_EMIT;
        ret_nxt = ST_IDLE;
      end

      // Write on a cached key: drop the old entry first.
      ST_WR_RM: begin
        valid_nxt[s_r] = 1'b0;
        if (PW'(s_r) < free_r) free_nxt = PW'(s_r);
        st_nxt  = ST_UL1;
        ret_nxt = ST_AC_START;
      end

      // Eviction walk from the oldest probationary entry.
      ST_AC_START: begin
        walk_nxt = head_r[0];
        st_nxt   = ST_AC_CHK;
      end

      ST_AC_CHK: begin
        if ((walk_r != NIL) && short_room) begin
          m_raddr = walk_s;
          st_nxt  = ST_RD_WAIT;
          ret_nxt = ST_AC_EV;
        end else if (short_room) begin
          res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_NO_ROOM, 1'b1);
          st_nxt  = ST_EMIT;
          ret_nxt = ST_IDLE;
        end else begin
          st_nxt = ST_NW_WR;
        end
      end

      ST_AC_EV: begin
        if (rdm_r.busy) begin
          walk_nxt = rdnext_r;
          st_nxt   = ST_AC_CHK;
        end else if (rdm_r.dirty) begin
          res_nxt = mk_res(KIND_WB, OUT_KEY_W'(rdkey_r), SLOT_W'(walk_s), STAT_OK, 1'b0);
          st_nxt  = ST_EMIT;
          ret_nxt = ST_AC_RM;
        end else begin
          st_nxt = ST_AC_RM;
        end
      end

      ST_AC_RM: begin
        valid_nxt[walk_s] = 1'b0;
        if (walk_r < free_r) free_nxt = walk_r;
        uslot_nxt = walk_s;
        uprev_nxt = rdprev_r;
        unext_nxt = rdnext_r;
        useg_nxt  = 1'b0;
        walk_nxt  = rdnext_r;
        st_nxt    = ST_UL1;
        ret_nxt   = ST_AC_CHK;
      end

      // Place the new entry in the lowest free slot.
      ST_NW_WR: begin
        m_waddr    = free_r[SW-1:0];
        m_we.key   = 1'b1;
        m_we.marks = 1'b1;
        m_wkey     = key_r;
        m_wmarks   = nm_r;
        valid_nxt[free_r[SW-1:0]] = 1'b1;
        s_nxt      = free_r[SW-1:0];
        aslot_nxt  = free_r[SW-1:0];
        aseg_nxt   = tgt_r;
        st_nxt     = ST_AP1;
        ret_nxt    = ST_NW_POST;
      end

      ST_NW_POST: begin
        if (op_r == OP_WRITE_THR) begin
          res_nxt = mk_res(KIND_WB, OUT_KEY_W'(key_r), SLOT_W'(s_r), STAT_OK, 1'b0);
          st_nxt  = ST_EMIT;
          ret_nxt = ST_FIN_OK;
        end else begin
          st_nxt = ST_FIN_OK;
        end
      end

      // Flush pass end: write back the smallest dirty key, or finish.
      ST_FL_END: begin
        if (bf_r) begin
          m_waddr        = bslot_r;
          m_we.marks     = 1'b1;
          m_wmarks       = bm_r;
          m_wmarks.dirty = 1'b0;
          res_nxt = mk_res(KIND_WB, OUT_KEY_W'(bkey_r), SLOT_W'(bslot_r), STAT_OK, 1'b0);
          st_nxt  = ST_EMIT;
          ret_nxt = ST_FL_START;
        end else begin
          res_nxt = mk_res(KIND_STATUS, OUT_KEY_W'(key_r), '0, STAT_OK, 1'b1);
          st_nxt  = ST_EMIT;
          ret_nxt = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      ret_r   <= ST_IDLE;
      valid_r <= '0;
      head_r  <= '{NIL, NIL};
      tail_r  <= '{NIL, NIL};
      cseg_r  <= '{'0, '0};
    end else begin
      st_r    <= st_nxt;
      ret_r   <= ret_nxt;
      valid_r <= valid_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cseg_r  <= cseg_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    cnt_r    <= cnt_nxt;
    pend_r   <= pend_nxt;
    pidx_r   <= pidx_nxt;
    found_r  <= found_nxt;
    s_r      <= s_nxt;
    swkey_r  <= swkey_nxt;
    swm_r    <= swm_nxt;
    swnext_r <= swnext_nxt;
    swprev_r <= swprev_nxt;
    free_r   <= free_nxt;
    bf_r     <= bf_nxt;
    bslot_r  <= bslot_nxt;
    bkey_r   <= bkey_nxt;
    bm_r     <= bm_nxt;
    rdkey_r  <= rdkey_nxt;
    rdm_r    <= rdm_nxt;
    rdnext_r <= rdnext_nxt;
    rdprev_r <= rdprev_nxt;
    uslot_r  <= uslot_nxt;
    uprev_r  <= uprev_nxt;
    unext_r  <= unext_nxt;
    useg_r   <= useg_nxt;
    aslot_r  <= aslot_nxt;
    aseg_r   <= aseg_nxt;
    tgt_r    <= tgt_nxt;
    nm_r     <= nm_nxt;
    walk_r   <= walk_nxt;
    res_r    <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/slru_cache_directory.sv =====
// Flow: a key scan over all ENTRIES slots, then segment list relinking; each
//   evicted entry adds a read and an unlink, and flush_all makes a further scan
//   pass for each dirty entry written back.
// Throughput: one word at a time, set by the scan over the entry memory's one read port.
// Reset (synchronous, rst_n low): no entry valid, segments empty, both limits 8.
//   No clearing pass; the first word is accepted right after reset.
// ----------------------------------------------------------------------------
// slru_cache_directory
// Segmented-LRU cache directory: configuration registers, output register,
// and the sequencer over the entry memory.
// ----------------------------------------------------------------------------
`default_nettype none

module slru_cache_directory
  import slru_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // opcode[3:0], key[35:4], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // item_key[31:0], slot[35:32], status[38:36], pad
  output logic [1:0]       out_tuser,  // kind[1:0]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  localparam int SW = $clog2(ENTRIES);
  localparam int PW = $clog2(ENTRIES + 1);

  logic [LIM_W-1:0]    plim_r, qlim_r;
  logic                out_valid_r;
  res_t                out_res_r;
  logic                res_valid, res_ready;
  res_t                res;
  logic [SW-1:0]       m_waddr, m_raddr;
  wen_t                m_we;
  logic [KEY_BITS-1:0] m_wkey, m_rkey;
  marks_t              m_wmarks, m_rmarks;
  logic [PW-1:0]       m_wnext, m_wprev, m_rnext, m_rprev;

  // Limit registers, written at any time the port is valid.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plim_r <= LIM_RESET;
      qlim_r <= LIM_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROBATION: plim_r <= cfg_data;
        CFG_PROTECTED: qlim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register parts the sequencer from the result channel.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.status, out_res_r.slot, out_res_r.key};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;

  slru_ctrl #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[3:0]),
    .in_key    (in_tdata[35:4]),
    .plim      (plim_r),
    .qlim      (qlim_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_waddr   (m_waddr),
    .m_we      (m_we),
    .m_wkey    (m_wkey),
    .m_wmarks  (m_wmarks),
    .m_wnext   (m_wnext),
    .m_wprev   (m_wprev),
    .m_raddr   (m_raddr),
    .m_rkey    (m_rkey),
    .m_rmarks  (m_rmarks),
    .m_rnext   (m_rnext),
    .m_rprev   (m_rprev)
  );

  slru_mem #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_mem (
    .clk    (clk),
    .waddr  (m_waddr),
    .we     (m_we),
    .wkey   (m_wkey),
    .wmarks (m_wmarks),
    .wnext  (m_wnext),
    .wprev  (m_wprev),
    .raddr  (m_raddr),
    .rkey   (m_rkey),
    .rmarks (m_rmarks),
    .rnext  (m_rnext),
    .rprev  (m_rprev)
  );

endmodule

`default_nettype wire

// ===== rtl/slru_chk.sv =====
// ----------------------------------------------------------------------------
// slru_chk
// Port-level checks of the cache directory, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slru_chk
  import slru_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // An accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a word");

  // Fetch and writeback words carry status ok and never close a run.
  a_side_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_STATUS) |->
      (out_tdata[38:36] == STAT_OK) && !out_tlast)
    else $error("fetch or writeback word with status or last set");

  // The last word of a run is the final status.
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == KIND_STATUS))
    else $error("last word is not a status word");

endmodule

bind slru_cache_directory slru_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
